>>> hw/rtl/fsnp_pkg.sv
// Package for the 8.3 short name packer.
// Holds the shared constants, the sequencer state type and the command and status structs.
`timescale 1ns / 1ps

package fsnp_pkg;

	localparam int BASE_LEN_DEF  = 8;
	localparam int TOTAL_LEN_DEF = 11;
	localparam int CHAR_DEPTH    = 8;
	localparam int CNT_W         = 4;
	localparam int IDX_W         = 4;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_DELETED = 8'hE5;
	localparam logic [7:0] CH_KANJI   = 8'h05;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_EMIT,
		ST_ERR
	} fsnp_state_t;

	typedef struct packed {
		logic       push_base;
		logic [7:0] base_data;
		logic       push_seg;
		logic [7:0] seg_data;
		logic       seg_clear;
		logic       set_dot;
		logic       set_started;
		logic       clear_all;
	} fsnp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] base_count;
		logic [CNT_W-1:0] seg_count;
		logic             dot_seen;
		logic             started;
	} fsnp_stat_t;

endpackage

>>> hw/rtl/fsnp_store.sv
// Character store of the short name packer: name and segment buffers with their counts.
// Depends on fsnp_pkg for the command and status structs.
`timescale 1ns / 1ps

module fsnp_store #(
	parameter int BASE_LEN = fsnp_pkg::BASE_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsnp_pkg::fsnp_cmd_t  cmd,
	input  logic [2:0]           base_raddr,
	input  logic [2:0]           seg_raddr,
	output logic [7:0]           base_rdata,
	output logic [7:0]           seg_rdata,
	output fsnp_pkg::fsnp_stat_t stat
);
	import fsnp_pkg::*;

	logic [7:0]       base_q [CHAR_DEPTH];
	logic [7:0]       seg_q  [CHAR_DEPTH];
	logic [CNT_W-1:0] base_count_q;
	logic [CNT_W-1:0] seg_count_q;
	logic             dot_seen_q;
	logic             started_q;
	logic             base_wr;
	logic             seg_wr;

	assign base_wr = cmd.push_base && (base_count_q < CNT_W'(BASE_LEN));
	assign seg_wr  = cmd.push_seg && (seg_count_q < CNT_W'(CHAR_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_count_q <= '0;
			seg_count_q  <= '0;
			dot_seen_q   <= 1'b0;
			started_q    <= 1'b0;
		end else if (cmd.clear_all) begin
			base_count_q <= '0;
			seg_count_q  <= '0;
			dot_seen_q   <= 1'b0;
			started_q    <= 1'b0;
		end else begin
			if (base_wr) begin
				base_count_q <= base_count_q + 1'b1;
			end
			if (cmd.seg_clear) begin
				seg_count_q <= '0;
			end else if (seg_wr) begin
				seg_count_q <= seg_count_q + 1'b1;
			end
			if (cmd.set_dot) begin
				dot_seen_q <= 1'b1;
			end
			if (cmd.set_started) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (base_wr) begin
			base_q[base_count_q[2:0]] <= cmd.base_data;
		end
		if (seg_wr) begin
			seg_q[seg_count_q[2:0]] <= cmd.seg_data;
		end
	end

	assign base_rdata      = base_q[base_raddr];
	assign seg_rdata       = seg_q[seg_raddr];
	assign stat.base_count = base_count_q;
	assign stat.seg_count  = seg_count_q;
	assign stat.dot_seen   = dot_seen_q;
	assign stat.started    = started_q;

endmodule

>>> hw/rtl/fat_short_name_pack.sv
// Top level of the 8.3 short name packer: sequencer, result register and assertions.
// Depends on fsnp_pkg and fsnp_store.
`timescale 1ns / 1ps

// A file name enters on the char channel one byte per item, ended by a zero byte.
// Letters are folded to upper case, spaces are dropped, and the last dot that is not
// the first byte splits name from extension. The zero byte makes the block send the
// TOTAL_LEN byte space-padded short name on the name channel, one byte per item with
// its position in byte_index and last set on the final byte. A zero byte with no name
// before it gives a single item with empty_error and last set.
// A dot that closes an earlier segment starts a merge of the dot and the kept segment
// bytes into the name, one byte a cycle through the single store write port. A zero
// byte starts the emission of the result. char_stall is high while a merge, an
// emission or an error item runs. Results go through one output register, so a
// stalled receiver holds the current result and pauses the emission. Reset clears
// the name state and the output valid flag; the next byte starts a name.
module fat_short_name_pack #(
	parameter int BASE_LEN  = fsnp_pkg::BASE_LEN_DEF,
	parameter int TOTAL_LEN = fsnp_pkg::TOTAL_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_byte,
	output logic       name_valid,
	input  logic       name_stall,
	output logic [7:0] out_byte,
	output logic [3:0] byte_index,
	output logic       last,
	output logic       empty_error
);
	import fsnp_pkg::*;

	localparam int NAME_SLOTS = (BASE_LEN < TOTAL_LEN) ? BASE_LEN : TOTAL_LEN;

	fsnp_state_t      state_q;
	fsnp_state_t      state_d;
	fsnp_cmd_t        cmd;
	fsnp_stat_t       stat;
	logic [2:0]       base_raddr;
	logic [2:0]       seg_raddr;
	logic [7:0]       base_rdata;
	logic [7:0]       seg_rdata;
	logic [CNT_W-1:0] merge_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] ext_idx;
	logic             char_acc;
	logic             out_free;
	logic             out_load;
	logic             emit_done;
	logic             merge_done;
	logic [7:0]       up_char;
	logic [7:0]       emit_byte;
	logic [7:0]       out_byte_d;
	logic             last_d;
	logic             err_d;
	logic             name_valid_q;
	logic [7:0]       out_byte_q;
	logic [3:0]       byte_index_q;
	logic             last_q;
	logic             empty_error_q;

	fsnp_store #(
		.BASE_LEN(BASE_LEN)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.base_raddr(base_raddr),
		.seg_raddr (seg_raddr),
		.base_rdata(base_rdata),
		.seg_rdata (seg_rdata),
		.stat      (stat)
	);

	assign char_stall = (state_q != ST_IDLE);
	assign char_acc   = char_valid && !char_stall;
	assign out_free   = !name_valid_q || !name_stall;
	assign emit_done  = (k_q == IDX_W'(TOTAL_LEN - 1));
	assign merge_done = (merge_q == stat.seg_count);
	assign ext_idx    = k_q - IDX_W'(BASE_LEN);

	always_comb begin
		up_char = char_byte;
		if (char_byte inside {[8'h61:8'h7A]}) begin
			up_char = char_byte - CASE_DIFF;
		end
	end

	always_comb begin
		emit_byte = CH_SPACE;
		if (k_q < IDX_W'(NAME_SLOTS)) begin
			if (k_q < stat.base_count) begin
				emit_byte = base_rdata;
			end
		end else if (stat.dot_seen && (ext_idx < stat.seg_count)) begin
			emit_byte = seg_rdata;
		end
		if ((k_q == '0) && (emit_byte == CH_DELETED)) begin
			emit_byte = CH_KANJI;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (char_acc) begin
					if (char_byte == CH_NUL) begin
						state_d = stat.started ? ST_EMIT : ST_ERR;
					end else if ((char_byte == CH_DOT) && stat.started && stat.dot_seen) begin
						state_d = ST_MERGE;
					end
				end
			end
			ST_MERGE: begin
				if (merge_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free && emit_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		base_raddr = k_q[2:0];
		seg_raddr  = ext_idx[2:0];
		out_load   = 1'b0;
		out_byte_d = emit_byte;
		last_d     = emit_done;
		err_d      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (char_acc && (char_byte != CH_NUL)) begin
					cmd.set_started = 1'b1;
					if ((char_byte == CH_DOT) && stat.started) begin
						if (!stat.dot_seen) begin
							cmd.seg_clear = 1'b1;
							cmd.set_dot   = 1'b1;
						end
					end else if (char_byte != CH_SPACE) begin
						cmd.push_base = !stat.dot_seen;
						cmd.push_seg  = stat.dot_seen;
					end
				end
				cmd.base_data = up_char;
				cmd.seg_data  = up_char;
			end
			ST_MERGE: begin
				seg_raddr     = 3'(merge_q - 1'b1);
				cmd.push_base = 1'b1;
				cmd.base_data = (merge_q == '0) ? CH_DOT : seg_rdata;
				cmd.seg_clear = merge_done;
			end
			ST_EMIT: begin
				out_load      = out_free;
				cmd.clear_all = out_free && emit_done;
			end
			ST_ERR: begin
				out_load      = out_free;
				out_byte_d    = CH_NUL;
				last_d        = 1'b1;
				err_d         = 1'b1;
				cmd.clear_all = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			merge_q      <= '0;
			k_q          <= '0;
			name_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MERGE) begin
				merge_q <= merge_q + 1'b1;
			end else begin
				merge_q <= '0;
			end
			if (state_q != ST_EMIT) begin
				k_q <= '0;
			end else if (out_load) begin
				k_q <= k_q + 1'b1;
			end
			if (out_load) begin
				name_valid_q <= 1'b1;
			end else if (!name_stall) begin
				name_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q    <= out_byte_d;
			byte_index_q  <= (state_q == ST_ERR) ? '0 : k_q;
			last_q        <= last_d;
			empty_error_q <= err_d;
		end
	end

	assign name_valid  = name_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_index  = byte_index_q;
	assign last        = last_q;
	assign empty_error = empty_error_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		name_valid && empty_error |-> last && (byte_index == '0))
		else $error("empty name item is not a single final item");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		name_valid && last && !empty_error |-> byte_index == IDX_W'(TOTAL_LEN - 1))
		else $error("final name item has the wrong position");

	a_base_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.base_count <= CNT_W'(BASE_LEN) && stat.seg_count <= CNT_W'(CHAR_DEPTH))
		else $error("character count beyond buffer capacity");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> !stat.started && (stat.base_count == '0))
		else $error("name state not cleared after the run");

endmodule

>>> sim/fat_short_name_pack_tb.sv
// Testbench for fat_short_name_pack: sends file names byte by byte and checks each short name byte.
// Depends on fsnp_pkg and the fat_short_name_pack RTL; predicts results with its own 8.3 packing model.
`timescale 1ns / 1ps

module fat_short_name_pack_tb;
	import fsnp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 380;
	localparam logic [7:0] CH_LOW_A = "a";
	localparam logic [7:0] CH_LOW_Z = "z";

	typedef struct {
		logic [7:0] out_byte;
		logic [3:0] byte_index;
		logic       last;
		logic       empty_error;
	} name_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	logic [7:0] char_byte = 8'h00;
	logic       name_valid;
	logic       name_stall = 1'b0;
	logic [7:0] out_byte;
	logic [3:0] byte_index;
	logic       last;
	logic       empty_error;

	name_byte_t short_name_q[$];
	logic [7:0] base_buf[CHAR_DEPTH];
	logic [7:0] seg_buf[CHAR_DEPTH];
	int         base_len;
	int         seg_len;
	bit         dot_flag;
	bit         name_started;

	bit idle_on = 1'b1;
	int hold_cycles = 0;
	int error_count = 0;
	int char_count = 0;
	int cycle_count = 0;

	fat_short_name_pack dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_byte(char_byte),
		.name_valid(name_valid),
		.name_stall(name_stall),
		.out_byte(out_byte),
		.byte_index(byte_index),
		.last(last),
		.empty_error(empty_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void clear_name();
		for (int i = 0; i < CHAR_DEPTH; i++) begin
			base_buf[i] = CH_SPACE;
			seg_buf[i] = CH_SPACE;
		end
		base_len = 0;
		seg_len = 0;
		dot_flag = 1'b0;
		name_started = 1'b0;
	endfunction

	function automatic void add_base(logic [7:0] c);
		if (base_len < BASE_LEN_DEF && base_len < CHAR_DEPTH) begin
			base_buf[base_len] = c;
			base_len++;
		end
	endfunction

	function automatic void emit_short_name();
		name_byte_t nb;
		logic [7:0] b;
		int         name_slots;
		int         e;
		name_slots = (BASE_LEN_DEF < TOTAL_LEN_DEF) ? BASE_LEN_DEF : TOTAL_LEN_DEF;
		for (int k = 0; k < TOTAL_LEN_DEF; k++) begin
			b = CH_SPACE;
			if (k < name_slots) begin
				if (k < base_len)
					b = base_buf[k];
			end else begin
				e = k - BASE_LEN_DEF;
				if (dot_flag && e < seg_len && e < CHAR_DEPTH)
					b = seg_buf[e];
			end
			if (k == 0 && b == CH_DELETED)
				b = CH_KANJI;
			nb.out_byte = b;
			nb.byte_index = k[3:0];
			nb.last = (k == TOTAL_LEN_DEF - 1);
			nb.empty_error = 1'b0;
			short_name_q.push_back(nb);
		end
	endfunction

	function automatic void pack_char(logic [7:0] c);
		name_byte_t nb;
		if (c != CH_NUL) begin
			if (c == CH_DOT && name_started) begin
				if (dot_flag) begin
					add_base(CH_DOT);
					for (int i = 0; i < seg_len; i++)
						add_base(seg_buf[i]);
				end
				for (int i = 0; i < CHAR_DEPTH; i++)
					seg_buf[i] = CH_SPACE;
				seg_len = 0;
				dot_flag = 1'b1;
			end else if (c != CH_SPACE) begin
				if (c >= CH_LOW_A && c <= CH_LOW_Z)
					c = c - CASE_DIFF;
				if (dot_flag) begin
					if (seg_len < CHAR_DEPTH) begin
						seg_buf[seg_len] = c;
						seg_len++;
					end
				end else begin
					add_base(c);
				end
			end
			name_started = 1'b1;
		end else if (!name_started) begin
			nb.out_byte = CH_NUL;
			nb.byte_index = '0;
			nb.last = 1'b1;
			nb.empty_error = 1'b1;
			short_name_q.push_back(nb);
			clear_name();
		end else begin
			emit_short_name();
			clear_name();
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		name_byte_t want;
		if (arst_n && name_valid && !name_stall) begin
			if (short_name_q.size() == 0) begin
				report_mismatch("unexpected item, out_byte", int'(out_byte), 0);
			end else begin
				want = short_name_q.pop_front();
				if (out_byte !== want.out_byte)
					report_mismatch("out_byte", int'(out_byte), int'(want.out_byte));
				if (byte_index !== want.byte_index)
					report_mismatch("byte_index", int'(byte_index),
						int'(want.byte_index));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
				if (empty_error !== want.empty_error)
					report_mismatch("empty_error", int'(empty_error),
						int'(want.empty_error));
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				name_stall <= 1'b1;
				hold_cycles--;
			end else begin
				name_stall <= idle_on && ($urandom_range(0, 99) < 32);
			end
		end
	end

	task automatic send_char(input logic [7:0] c);
		while (idle_on && $urandom_range(0, 99) < 32) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte <= c;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		pack_char(c);
		char_count++;
	endtask

	task automatic send_name(input logic [7:0] lead, input string s);
		if (lead != CH_NUL)
			send_char(lead);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(CH_NUL);
	endtask

	function automatic logic [7:0] pick_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
		else if (roll < 52)
			return 8'($urandom_range("A", "Z"));
		else if (roll < 60)
			return 8'($urandom_range("0", "9"));
		else if (roll < 75)
			return CH_DOT;
		else if (roll < 83)
			return CH_SPACE;
		else
			return 8'($urandom_range(1, 255));
	endfunction

	task automatic send_random_name();
		int         len;
		logic [7:0] c;
		if ($urandom_range(0, 99) < 5) begin
			send_char(CH_NUL);
		end else begin
			len = ($urandom_range(0, 99) < 20) ? $urandom_range(9, 22) : $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				c = pick_char();
				if (i == 0 && $urandom_range(0, 99) < 8)
					c = CH_DELETED;
				send_char(c);
			end
			send_char(CH_NUL);
		end
	endtask

	task automatic wait_idle();
		char_valid <= 1'b0;
		@(posedge clk);
		while (short_name_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_name(CH_NUL, "");
		send_name(CH_NUL, ".x.yz");
		send_name(CH_NUL, " .a");
		send_name(CH_DELETED, ".q.z");
		send_name(8'hFF, "a`z{ ");
		send_name(8'h80, "b..c");
		wait_idle();
	endtask

	task automatic test_random_names(input int target);
		while (char_count < target)
			send_random_name();
		wait_idle();
	endtask

	task automatic test_no_idling(input int target);
		idle_on = 1'b0;
		while (char_count < target)
			send_random_name();
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_output_hold();
		hold_cycles = HOLD_CYCLES;
		for (int n = 0; n < 4; n++)
			send_random_name();
		wait_idle();
	endtask

	initial begin
		clear_name();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_names(ITEM_TARGET / 2);
		test_no_idling(ITEM_TARGET * 3 / 4);
		test_output_hold();
		test_random_names(ITEM_TARGET);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
